/* hw/rtl/bfc_pkg.sv */
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants of the box versus view frustum cull test.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int DIGIT_BITS = 32;
  localparam int NUM_PLANES = 6;

  localparam logic [1:0] REQ_LOAD_PROJ = 2'd0;
  localparam logic [1:0] REQ_LOAD_VIEW = 2'd1;
  localparam logic [1:0] REQ_TEST_BOX  = 2'd2;

  localparam logic [NUM_PLANES-1:0] MASK_ALL = {NUM_PLANES{1'b1}};

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] corner_a_z;
    logic signed [31:0] corner_b_x;
    logic signed [31:0] corner_b_y;
    logic signed [31:0] corner_b_z;
  } bfc_in_t;

  typedef struct packed {
    logic       visible;
    logic [5:0] outside_mask;
  } bfc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_ADD,
    ST_DONE,
    ST_OUT
  } bfc_state_t;

  typedef struct packed {
    logic acc_load;
    logic mul_en;
    logic mul_first;
    logic acc_add;
    logic done_step;
    logic busy;
    logic out_valid;
  } bfc_ctl_t;

endpackage

/* hw/rtl/box_frustum_cull_test_core.sv */
// ----------------------------------------------------------------------------
// box_frustum_cull_test_core
// Axis-aligned box versus view frustum cull test on one shared MAC unit.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Item
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_data    | matrix element load or box test
//  result  | out_valid, out_stall, out_data | visible flag and outside mask
//  config  | cfg_wr_en, cfg_wr_data         | left-handed view select
//
//  A load writes its matrix element as it is accepted. A box test walks
//  the eight corners in turn on the digit-serial multiplier: three view
//  sums, then six plane sums, each from three terms and a constant.
//  in_stall is high from the start of a test until its item is taken.
//  Reset clears both matrices and the handedness; out_stall holds the item.
// ----------------------------------------------------------------------------
module box_frustum_cull_test_core import bfc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bfc_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  localparam int V    = VALUE_BITS;
  localparam int AW   = V + 1;                  // plane coefficient
  localparam int BW   = 2 * V + 3;              // view coordinate
  localparam int ACCW = 3 * V + 6;              // plane value
  localparam int NB   = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int NC   = (V + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIGW = (NB > 1) ? $clog2(NB) : 1;

  function automatic logic signed [V-1:0] take_val(input logic signed [31:0] x);
    take_val = V'(x);
  endfunction

  bfc_ctl_t              ctl;
  logic                  plane_ph;
  logic [2:0]            corner, sum_idx;
  logic [1:0]            term;
  logic [DIGW-1:0]       dig;
  logic                  accept, start;

  logic signed [V-1:0]   proj_r [16];
  logic signed [V-1:0]   view_r [16];
  logic signed [V-1:0]   ca_r [3];
  logic signed [V-1:0]   cb_r [3];
  logic signed [BW-1:0]  vc_r [3];
  logic signed [AW-1:0]  plane_coef [NUM_PLANES][4];
  logic [NUM_PLANES-1:0] mask_r;
  logic                  lh_r;

  logic signed [AW-1:0]   op_a;
  logic signed [BW-1:0]   op_b;
  logic signed [ACCW-1:0] op_c, acc;
  logic signed [V-1:0]    coord;
  logic signed [BW-1:0]   view_val;

  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_data.req_type == REQ_TEST_BOX);
  assign in_stall = ctl.busy;

  // planes: row four plus or minus rows one to three
  for (genvar gj = 0; gj < NUM_PLANES; gj++) begin : g_plane
    for (genvar gk = 0; gk < 4; gk++) begin : g_coef
      if (gj % 2 == 0) begin : g_add
        assign plane_coef[gj][gk] = AW'(proj_r[12 + gk]) + AW'(proj_r[(gj / 2) * 4 + gk]);
      end else begin : g_sub
        assign plane_coef[gj][gk] = AW'(proj_r[12 + gk]) - AW'(proj_r[(gj / 2) * 4 + gk]);
      end
    end
  end

  // corner picks a or b per axis from its index bits
  always_comb begin
    unique case (term)
      2'd0:    coord = corner[0] ? cb_r[0] : ca_r[0];
      2'd1:    coord = corner[1] ? cb_r[1] : ca_r[1];
      2'd2:    coord = corner[2] ? cb_r[2] : ca_r[2];
      default: coord = '0;
    endcase
  end

  always_comb begin
    if (plane_ph) begin
      op_a = plane_coef[sum_idx][term];
      op_b = (term == 2'd3) ? BW'(0) : vc_r[term];
      op_c = ACCW'(plane_coef[sum_idx][3]) <<< 32;
    end else begin
      op_a = AW'(view_r[{sum_idx[1:0], term}]);
      op_b = BW'(coord);
      op_c = ACCW'(view_r[{sum_idx[1:0], 2'd3}]) <<< 16;
    end
  end

  // negate view z in left-handed mode
  assign view_val = (lh_r && sum_idx[1:0] == 2'd2) ? -BW'(acc) : BW'(acc);

  bfc_seq #(.NB(NB), .NC(NC), .DIGW(DIGW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_stall(out_stall),
    .ctl      (ctl),
    .plane_ph (plane_ph),
    .corner   (corner),
    .sum_idx  (sum_idx),
    .term     (term),
    .dig      (dig)
  );

  bfc_mac #(.AW(AW), .BW(BW), .NB(NB), .DIGW(DIGW), .ACCW(ACCW)) u_mac (
    .clk(clk),
    .ctl(ctl),
    .a  (op_a),
    .b  (op_b),
    .dig(dig),
    .cst(op_c),
    .acc(acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lh_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        proj_r[i] <= '0;
        view_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) lh_r <= cfg_wr_data;
      if (accept && in_data.req_type == REQ_LOAD_PROJ) begin
        proj_r[in_data.elem_index] <= take_val(in_data.elem_value);
      end
      if (accept && in_data.req_type == REQ_LOAD_VIEW) begin
        view_r[in_data.elem_index] <= take_val(in_data.elem_value);
      end
    end
  end

  // box corners, view coordinates and mask: payload, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      ca_r[0] <= take_val(in_data.corner_a_x);
      ca_r[1] <= take_val(in_data.corner_a_y);
      ca_r[2] <= take_val(in_data.corner_a_z);
      cb_r[0] <= take_val(in_data.corner_b_x);
      cb_r[1] <= take_val(in_data.corner_b_y);
      cb_r[2] <= take_val(in_data.corner_b_z);
      mask_r  <= MASK_ALL;
    end
    if (ctl.done_step && !plane_ph) begin
      vc_r[sum_idx[1:0]] <= view_val;
    end
    // drop the plane once any corner is on or inside it
    if (ctl.done_step && plane_ph && !acc[ACCW-1]) begin
      mask_r[sum_idx] <= 1'b0;
    end
  end

  assign out_valid             = ctl.out_valid;
  assign out_data.outside_mask = mask_r;
  assign out_data.visible      = (mask_r == '0);

endmodule

/* hw/rtl/bfc_mac.sv */
// ----------------------------------------------------------------------------
// bfc_mac
// Shared multiply-accumulate unit: digit-serial product, wide accumulator.
// ----------------------------------------------------------------------------
module bfc_mac import bfc_pkg::*; #(
  parameter int AW   = 33,
  parameter int BW   = 67,
  parameter int NB   = 3,
  parameter int DIGW = 2,
  parameter int ACCW = 102
) (
  input  logic                   clk,
  input  bfc_ctl_t               ctl,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  input  logic [DIGW-1:0]        dig,
  input  logic signed [ACCW-1:0] cst,
  output logic signed [ACCW-1:0] acc
);

  localparam int PW = AW + BW;
  localparam int XW = NB * DIGIT_BITS;

  logic signed [XW-1:0]         bext;
  logic [DIGIT_BITS-1:0]        digit;
  logic signed [DIGIT_BITS:0]   digit_s;
  logic signed [AW+DIGIT_BITS:0] prod;
  logic signed [PW-1:0]         p_r, p_nxt;
  logic signed [ACCW-1:0]       acc_r, acc_nxt;

  assign bext    = XW'(b);
  assign digit   = bext[dig*DIGIT_BITS +: DIGIT_BITS];
  // top digit carries the sign, lower digits are plain magnitude
  assign digit_s = {ctl.mul_first & digit[DIGIT_BITS-1], digit};
  assign prod    = a * digit_s;

  always_comb begin
    p_nxt = p_r;
    if (ctl.mul_en) begin
      p_nxt = (ctl.mul_first ? PW'(0) : (p_r <<< DIGIT_BITS)) + PW'(prod);
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_load) begin
      acc_nxt = cst;
    end else if (ctl.acc_add) begin
      acc_nxt = acc_r + ACCW'(p_r);
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* hw/rtl/bfc_seq.sv */
// ----------------------------------------------------------------------------
// bfc_seq
// Sequencer: walks corners, sums, terms and digits for the shared unit.
// ----------------------------------------------------------------------------
module bfc_seq import bfc_pkg::*; #(
  parameter int NB   = 3,
  parameter int NC   = 1,
  parameter int DIGW = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_stall,
  output bfc_ctl_t        ctl,
  output logic            plane_ph,
  output logic [2:0]      corner,
  output logic [2:0]      sum_idx,
  output logic [1:0]      term,
  output logic [DIGW-1:0] dig
);

  bfc_state_t      state_r, state_nxt;
  logic            plane_r;
  logic [2:0]      corner_r;
  logic [2:0]      sum_r;
  logic [1:0]      term_r;
  logic [DIGW-1:0] dig_r, top_dig;
  logic            last_sum;

  assign top_dig  = plane_r ? DIGW'(NB - 1) : DIGW'(NC - 1);
  assign last_sum = plane_r ? (sum_r == 3'(NUM_PLANES - 1)) : (sum_r == 3'd2);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_MUL;
      ST_MUL:  if (dig_r == '0) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = (term_r == 2'd2) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        state_nxt = (plane_r && last_sum && corner_r == 3'd7) ? ST_OUT : ST_INIT;
      end
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.busy      = (state_r != ST_IDLE);
    ctl.acc_load  = (state_r == ST_INIT);
    ctl.mul_en    = (state_r == ST_MUL);
    ctl.mul_first = (state_r == ST_MUL) && (dig_r == top_dig);
    ctl.acc_add   = (state_r == ST_ADD);
    ctl.done_step = (state_r == ST_DONE);
    ctl.out_valid = (state_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      plane_r  <= 1'b0;
      corner_r <= '0;
      sum_r    <= '0;
      term_r   <= '0;
      dig_r    <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          plane_r  <= 1'b0;
          corner_r <= '0;
          sum_r    <= '0;
        end
        ST_INIT: begin
          term_r <= '0;
          dig_r  <= top_dig;
        end
        ST_MUL:  if (dig_r != '0) dig_r <= dig_r - 1'b1;
        ST_ADD: begin
          term_r <= term_r + 1'b1;
          dig_r  <= top_dig;
        end
        ST_DONE: begin
          // advance to the next sum, phase or corner
          if (!last_sum) begin
            sum_r <= sum_r + 1'b1;
          end else begin
            sum_r   <= '0;
            plane_r <= !plane_r;
            if (plane_r) corner_r <= corner_r + 1'b1;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign plane_ph = plane_r;
  assign corner   = corner_r;
  assign sum_idx  = sum_r;
  assign term     = term_r;
  assign dig      = dig_r;

endmodule

/* hw/rtl/bfc_chk.sv */
// ----------------------------------------------------------------------------
// bfc_chk
// Port-level checks of the cull test core, bound to the top level.
// ----------------------------------------------------------------------------
module bfc_chk import bfc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input bfc_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input bfc_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_vis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.visible == (out_data.outside_mask == 6'd0))
    else $error("visible disagrees with outside mask");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type != REQ_TEST_BOX |=> !out_valid)
    else $error("result produced for a non-test item");

endmodule

bind box_frustum_cull_test_core bfc_chk u_bfc_chk (.*);
